[src/skt_pkg.sv]
`timescale 1ns / 1ps
// skt_pkg: field widths, command and status codes, entry type and sequencer states
// for the sorted key table; no dependencies

package skt_pkg;

  localparam int CMD_W    = 2;
  localparam int KEY_W    = 31;
  localparam int HANDLE_W = 16;
  localparam int STATUS_W = 3;
  localparam int FILL_W   = 6;

  localparam logic [CMD_W-1:0] CMD_INSERT    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LIST_ALL  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_LIST_FLAG = 2'd3;

  localparam logic [STATUS_W-1:0] ST_DONE     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ENTRY    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
    logic                flag;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_DEL_RD,
    S_DEL_CMP,
    S_LST_RD,
    S_LST_CMP,
    S_RESP
  } state_t;

endpackage

[src/skt_ifs.sv]
`timescale 1ns / 1ps
// skt_in_if and skt_out_if: valid/ready channels for command beats and result beats
// depends on skt_pkg

interface skt_in_if import skt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [KEY_W-1:0]    key;
  logic [HANDLE_W-1:0] record_handle;
  logic                unvaccinated;

  modport source (output valid, cmd, key, record_handle, unvaccinated, input ready);
  modport sink   (input valid, cmd, key, record_handle, unvaccinated, output ready);
endinterface

interface skt_out_if import skt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [KEY_W-1:0]    entry_key;
  logic [HANDLE_W-1:0] entry_handle;
  logic                entry_flag;
  logic [FILL_W-1:0]   fill_count;
  logic                last;

  modport source (output valid, status, entry_key, entry_handle, entry_flag, fill_count, last,
                  input ready);
  modport sink   (input valid, status, entry_key, entry_handle, entry_flag, fill_count, last,
                  output ready);
endinterface

[src/sorted_key_table_unit.sv]
`timescale 1ns / 1ps
// sorted_key_table_unit: sorted table of key/handle/flag entries in one synchronous memory
// depends on skt_pkg and the channel interfaces in skt_ifs

// The table holds up to DEPTH entries in ascending key order in a single memory with one
// write and one registered read port. Every command takes one beat and works through the
// memory one entry at a time (read, then compare and, when an entry moves or lands, write):
// insert scans from the top down and moves every larger key one slot up; delete scans
// from the bottom for the first equal key and moves the rest of the table down; a listing
// reads every held entry. A full insert answers ST_FULL without touching the memory.
// A new command beat is taken once the previous command has handed its final result to the
// output register, so the input side does not wait on a slow result consumer beyond that.
// Listings hold back one matched entry so the final one can carry last. After reset the
// table is empty and no clearing pass is needed: only entries below the fill count are read.

module sorted_key_table_unit import skt_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  skt_in_if.sink     in_ch,
  skt_out_if.source  out_ch
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  // entry memory, read data registered
  entry_t mem [DEPTH];
  entry_t rd_data_r;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;

  // sequencer and command registers
  state_t              state_r, state_nxt;
  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  entry_t              new_r, new_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic                found_r, found_nxt;
  logic                pend_valid_r, pend_valid_nxt;
  entry_t              pend_r, pend_nxt;
  logic [STATUS_W-1:0] resp_r, resp_nxt;

  // result register
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  entry_t              out_entry_r;
  logic [FILL_W-1:0]   out_fill_r;
  logic                out_last_r;

  logic                emit;
  logic [STATUS_W-1:0] emit_status;
  entry_t              emit_entry;
  logic                emit_last;

  logic          out_free;
  logic          accept;
  logic [CW-1:0] idx_dec;
  logic          list_match;

  assign out_free   = !out_valid_r || out_ch.ready;
  assign accept     = in_ch.valid && in_ch.ready;
  assign idx_dec    = idx_r - 1'b1;
  assign list_match = (cmd_r == CMD_LIST_ALL) || rd_data_r.flag;

  assign in_ch.ready = (state_r == S_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          case (in_ch.cmd)
            CMD_INSERT: state_nxt = (count_r == CW'(DEPTH)) ? S_RESP : S_INS_RD;
            CMD_DELETE: state_nxt = S_DEL_RD;
            default:    state_nxt = S_LST_RD;
          endcase
        end
      end
      S_INS_RD:  state_nxt = (idx_r == '0) ? S_RESP : S_INS_CMP;
      S_INS_CMP: state_nxt = (rd_data_r.key > new_r.key) ? S_INS_RD : S_RESP;
      S_DEL_RD:  state_nxt = (idx_r == count_r) ? S_RESP : S_DEL_CMP;
      S_DEL_CMP: state_nxt = S_DEL_RD;
      S_LST_RD: begin
        if (idx_r != count_r) begin
          state_nxt = S_LST_CMP;
        end else if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_LST_CMP: begin
        if (!(list_match && pend_valid_r && !out_free)) begin
          state_nxt = S_LST_RD;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath, memory strobes and result beats
  always_comb begin
    cmd_nxt        = cmd_r;
    new_nxt        = new_r;
    idx_nxt        = idx_r;
    count_nxt      = count_r;
    found_nxt      = found_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    resp_nxt       = resp_r;
    mem_we         = 1'b0;
    mem_waddr      = idx_r[AW-1:0];
    mem_wdata      = new_r;
    mem_re         = 1'b0;
    mem_raddr      = idx_r[AW-1:0];
    emit           = 1'b0;
    emit_status    = ST_DONE;
    emit_entry     = '0;
    emit_last      = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt        = in_ch.cmd;
          new_nxt        = '{key: in_ch.key, handle: in_ch.record_handle,
                             flag: in_ch.unvaccinated};
          idx_nxt        = (in_ch.cmd == CMD_INSERT) ? count_r : '0;
          found_nxt      = 1'b0;
          pend_valid_nxt = 1'b0;
          resp_nxt       = ST_FULL;
        end
      end
      S_INS_RD: begin
        if (idx_r == '0) begin
          // new key is below everything left: goes to the front
          mem_we    = 1'b1;
          count_nxt = count_r + 1'b1;
          resp_nxt  = ST_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_dec[AW-1:0];
        end
      end
      S_INS_CMP: begin
        mem_we = 1'b1;
        if (rd_data_r.key > new_r.key) begin
          // larger key moves up one slot
          mem_wdata = rd_data_r;
          idx_nxt   = idx_dec;
        end else begin
          // equal or smaller key below: new entry lands just above it
          count_nxt = count_r + 1'b1;
          resp_nxt  = ST_DONE;
        end
      end
      S_DEL_RD: begin
        if (idx_r == count_r) begin
          resp_nxt = found_r ? ST_DONE : ST_NOTFOUND;
          if (found_r) begin
            count_nxt = count_r - 1'b1;
          end
        end else begin
          mem_re = 1'b1;
        end
      end
      S_DEL_CMP: begin
        if (found_r) begin
          // close the gap
          mem_we    = 1'b1;
          mem_waddr = idx_dec[AW-1:0];
          mem_wdata = rd_data_r;
        end else if (rd_data_r.key == new_r.key) begin
          found_nxt = 1'b1;
        end
        idx_nxt = idx_r + 1'b1;
      end
      S_LST_RD: begin
        if (idx_r == count_r) begin
          if (out_free) begin
            emit        = 1'b1;
            emit_status = pend_valid_r ? ST_ENTRY : ST_EMPTY;
            emit_entry  = pend_valid_r ? pend_r : '0;
          end
        end else begin
          mem_re = 1'b1;
        end
      end
      S_LST_CMP: begin
        if (!list_match) begin
          idx_nxt = idx_r + 1'b1;
        end else if (!pend_valid_r || out_free) begin
          // a later match exists, so the held one is not last
          if (pend_valid_r) begin
            emit        = 1'b1;
            emit_status = ST_ENTRY;
            emit_entry  = pend_r;
            emit_last   = 1'b0;
          end
          pend_nxt       = rd_data_r;
          pend_valid_nxt = 1'b1;
          idx_nxt        = idx_r + 1'b1;
        end
      end
      S_RESP: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_status = resp_r;
        end
      end
      default: ;
    endcase
  end

  // memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      found_r      <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      found_r      <= found_nxt;
      pend_valid_r <= pend_valid_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    new_r  <= new_nxt;
    idx_r  <= idx_nxt;
    pend_r <= pend_nxt;
    resp_r <= resp_nxt;
    if (emit) begin
      out_status_r <= emit_status;
      out_entry_r  <= emit_entry;
      out_fill_r   <= FILL_W'(count_r);
      out_last_r   <= emit_last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.entry_key    = out_entry_r.key;
  assign out_ch.entry_handle = out_entry_r.handle;
  assign out_ch.entry_flag   = out_entry_r.flag;
  assign out_ch.fill_count   = out_fill_r;
  assign out_ch.last         = out_last_r;

endmodule

[src/skt_checker.sv]
`timescale 1ns / 1ps
// skt_checker: port-level checks on the sorted key table, bound to its top level
// depends on skt_pkg and sorted_key_table_unit

module skt_checker import skt_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] out_status,
  input logic [KEY_W-1:0]    out_key,
  input logic [HANDLE_W-1:0] out_handle,
  input logic                out_flag,
  input logic [FILL_W-1:0]   out_fill,
  input logic                out_last
);

  // one command at a time: taking a beat closes the input
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a command is in flight");

  // only listed entries carry entry fields
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_ENTRY |->
      out_key == '0 && out_handle == '0 && !out_flag)
    else $error("entry fields set on a non-entry result");

  // everything but a listed entry is a single, final beat
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_ENTRY |-> out_last)
    else $error("non-entry result without last");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_key) &&
      $stable(out_handle) && $stable(out_flag) && $stable(out_fill) && $stable(out_last))
    else $error("result beat changed while stalled");

endmodule

bind sorted_key_table_unit skt_checker u_skt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_key    (out_ch.entry_key),
  .out_handle (out_ch.entry_handle),
  .out_flag   (out_ch.entry_flag),
  .out_fill   (out_ch.fill_count),
  .out_last   (out_ch.last)
);
